### rtl/bdgf_pkg.sv
// shared types and constants of the barcode duplicate group filter
`timescale 1ns / 1ps
package bdgf_pkg;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  localparam logic [1:0] VERDICT_KEPT = 2'd0;
  localparam logic [1:0] VERDICT_TOO_MANY = 2'd1;
  localparam logic [1:0] VERDICT_TOO_FAR = 2'd2;

  localparam logic [1:0] REG_MAX_DUP = 2'd0;
  localparam logic [1:0] REG_MAX_DIST = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;

  // classified record handed from front to back
  typedef struct packed {
    logic        last;
    logic [62:0] key;
    logic [33:0] sx;   // signed pixel value for x, before scaling
    logic [33:0] sy;   // signed pixel value for y, before scaling
  } rec_t;
endpackage

### rtl/bdgf_front.sv
// front end: tile table, input classification and record queue
`timescale 1ns / 1ps
module bdgf_front #(
  parameter int TILE_COUNT = 64,
  parameter int QDEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                opcode,
  input  logic [5:0]          tile_index,
  input  logic [62:0]         barcode_key,
  input  logic [23:0]         pixel_x,
  input  logic [23:0]         pixel_y,
  input  logic [31:0]         base_x,
  input  logic signed [32:0]  base_y,
  input  logic                last_in_group,
  output logic                busy,
  output logic                q_valid,
  output bdgf_pkg::rec_t      q_data,
  input  logic                q_pop,
  output logic                idle
);
  localparam int TW = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
  localparam int QW = $clog2(QDEPTH);

  logic [31:0] mem_x [TILE_COUNT];
  logic [32:0] mem_y [TILE_COUNT];

  logic        acc;
  logic        tile_ok;
  logic [TW-1:0] tidx;
  assign acc = start && !busy;
  assign tile_ok = ({26'd0, tile_index} < TILE_COUNT);
  assign tidx = TW'(tile_index);

  // stage 1: registered table read
  logic        s1_valid;
  logic        s1_ok;
  logic        s1_last;
  logic [62:0] s1_key;
  logic [23:0] s1_px;
  logic [23:0] s1_py;
  logic [31:0] s1_bx;
  logic [32:0] s1_by;

  always_ff @(posedge clk) begin
    if (acc && opcode == bdgf_pkg::OP_LOAD && tile_ok) begin
      mem_x[tidx] <= base_x;
      mem_y[tidx] <= base_y;
    end
    s1_bx <= mem_x[tidx];
    s1_by <= mem_y[tidx];
    if (acc) begin
      s1_ok <= tile_ok;
      s1_last <= last_in_group;
      s1_key <= barcode_key;
      s1_px <= pixel_x;
      s1_py <= pixel_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= acc && opcode == bdgf_pkg::OP_RECORD;
  end

  bdgf_pkg::rec_t s1_rec;
  logic [31:0] bx;
  logic [32:0] by;
  always_comb begin
    bx = s1_ok ? s1_bx : 32'd0;
    by = s1_ok ? s1_by : 33'd0;
    s1_rec.last = s1_last;
    s1_rec.key = s1_key;
    s1_rec.sx = {2'b00, bx} - {10'd0, s1_px};
    s1_rec.sy = {by[32], by} + {10'd0, s1_py};
  end

  bdgf_pkg::rec_t q [QDEPTH];
  logic [QW-1:0] rd;
  logic [QW-1:0] wr;
  logic [QW:0]   cnt;

  always_ff @(posedge clk) begin
    if (s1_valid) q[wr] <= s1_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= '0;
      wr <= '0;
      cnt <= '0;
    end else begin
      if (s1_valid) wr <= (wr == QW'(QDEPTH - 1)) ? '0 : wr + 1'b1;
      if (q_pop) rd <= (rd == QW'(QDEPTH - 1)) ? '0 : rd + 1'b1;
      cnt <= cnt + (QW+1)'(s1_valid) - (QW+1)'(q_pop);
    end
  end

  assign q_valid = (cnt != '0);
  assign q_data = q[rd];
  // keep a slot for the record in flight through stage 1
  assign busy = (cnt + (QW+1)'(s1_valid)) >= (QW+1)'(QDEPTH);
  assign idle = !s1_valid && (cnt == '0);
endmodule

### rtl/bdgf_back.sv
// back end: scaling, pairwise distance with one shared multiplier, verdict
`timescale 1ns / 1ps
module bdgf_back #(
  parameter int GROUP_DEPTH = 8,
  parameter int COORD_BITS = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  bdgf_pkg::rec_t         q_data,
  output logic                   q_pop,
  input  logic [3:0]             max_duplicates,
  input  logic [30:0]            max_distance_nm,
  input  logic [15:0]            pixel_scale,
  output logic                   done,
  output logic [1:0]             verdict,
  output logic [7:0]             group_size,
  output logic [62:0]            max_distance_sq,
  output logic [30:0]            out_x,
  output logic [30:0]            out_y,
  output logic [62:0]            out_key,
  output logic                   idle
);
  localparam int GW = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
  localparam logic [COORD_BITS-1:0] CMAX = '1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCX  = 3'd1;
  localparam logic [2:0] S_SCY  = 3'd2;
  localparam logic [2:0] S_DX   = 3'd3;
  localparam logic [2:0] S_DY   = 3'd4;
  localparam logic [2:0] S_END  = 3'd5;
  localparam logic [2:0] S_THR  = 3'd6;

  logic [2:0] state;
  bdgf_pkg::rec_t rec;
  logic [COORD_BITS-1:0] gx;
  logic [COORD_BITS-1:0] gy;
  logic [COORD_BITS-1:0] st_x [GROUP_DEPTH];
  logic [COORD_BITS-1:0] st_y [GROUP_DEPTH];
  logic [COORD_BITS-1:0] rx;
  logic [COORD_BITS-1:0] ry;
  logic [7:0]  count;
  logic [62:0] run_max;
  logic [62:0] key;
  logic [62:0] dsq;
  logic [GW:0] k;
  logic [3:0]  limit;

  assign limit = ({28'd0, max_duplicates} > GROUP_DEPTH) ? 4'(GROUP_DEPTH) : max_duplicates;

  // shared multiplier operands
  logic [33:0] ma;
  logic [33:0] mb;
  logic [67:0] prod;
  logic [33:0] sv;
  logic [COORD_BITS-1:0] da;
  logic [COORD_BITS-1:0] db;
  logic [COORD_BITS-1:0] dd;
  logic [59:0] sc;
  always_comb begin
    sv = (state == S_SCX) ? rec.sx : rec.sy;
    da = (state == S_DX) ? gx : gy;
    db = (state == S_DX) ? rx : ry;
    dd = (da > db) ? da - db : db - da;
    case (state)
      S_SCX, S_SCY: begin
        ma = sv;
        mb = {18'd0, pixel_scale};
      end
      S_THR: begin
        ma = {3'd0, max_distance_nm};
        mb = {3'd0, max_distance_nm};
      end
      default: begin
        ma = 34'(dd);
        mb = 34'(dd);
      end
    endcase
    prod = ma * mb;
    sc = prod[67:8];
  end

  logic [COORD_BITS-1:0] scaled;
  assign scaled = sv[33] || sv == '0 ? '0 :
                  (sc > 60'(CMAX)) ? CMAX : COORD_BITS'(sc);

  logic stored_ok;
  assign stored_ok = ({24'd0, count} < 32'(limit));
  logic [GW-1:0] cidx;
  assign cidx = GW'(count);

  // rx/ry are registered reads; S_DY fetches the next point so the following S_DX sees it
  logic [GW-1:0] kr;
  assign kr = (state == S_DY) ? GW'(k + 1'b1) : GW'(k);

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) rec <= q_data;
    if (state == S_SCX) gx <= scaled;
    if (state == S_SCY) gy <= scaled;
    if (state == S_DX) dsq <= 63'(prod);
    if (state == S_END && stored_ok) begin
      st_x[cidx] <= gx;
      st_y[cidx] <= gy;
    end
    rx <= st_x[kr];
    ry <= st_y[kr];
  end

  logic [62:0] thr;
  logic [62:0] fx;
  logic [62:0] fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      run_max <= '0;
      key <= '0;
      k <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (q_valid) state <= S_SCX;
        S_SCX: begin
          state <= S_SCY;
          if (count == '0) key <= rec.key;
          k <= '0;
        end
        S_SCY: state <= (stored_ok && count != '0) ? S_DX : S_END;
        S_DX: state <= S_DY;
        S_DY: begin
          if (dsq + 63'(prod) > run_max) run_max <= dsq + 63'(prod);
          k <= k + 1'b1;
          state <= ((k + 1'b1) == (GW+1)'(count)) ? S_END : S_DX;
        end
        S_END: begin
          if (count != 8'hff) count <= count + 1'b1;
          state <= rec.last ? S_THR : S_IDLE;
        end
        S_THR: begin
          done <= 1'b1;
          count <= '0;
          run_max <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign thr = 63'(prod);
  assign fx = 63'(st_y[0]);
  assign fy = 63'(st_x[0]);
  logic too_many;
  assign too_many = ({24'd0, count} > 32'(limit));

  always_ff @(posedge clk) begin
    if (state == S_THR) begin
      group_size <= count;
      out_key <= key;
      verdict <= too_many ? bdgf_pkg::VERDICT_TOO_MANY :
                 (run_max > thr) ? bdgf_pkg::VERDICT_TOO_FAR : bdgf_pkg::VERDICT_KEPT;
      max_distance_sq <= too_many ? '0 : run_max;
      out_x <= too_many ? '0 : 31'(fx);
      out_y <= too_many ? '0 : 31'(fy);
    end
  end

  assign q_pop = (state == S_IDLE) && q_valid;
  assign idle = (state == S_IDLE);
endmodule

### rtl/barcode_duplicate_group_filter.sv
// top level of the barcode duplicate group filter
// a load writes the tile table when accepted; a record passes the stage 1 register and the queue
// the back end takes one record at a time from idle: scale x, scale y, a distance pair per stored
// point in the shared multiplier loop, group end; the last record adds a threshold square step
// reset: synchronous rst clears control state and the configuration registers; tile table undefined
// results are strobed for one cycle on done; the receiver cannot stall
`timescale 1ns / 1ps
module barcode_duplicate_group_filter #(
  parameter int TILE_COUNT = 64,
  parameter int GROUP_DEPTH = 8,
  parameter int COORD_BITS = 31
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic [5:0]         tile_index,
  input  logic [62:0]        barcode_key,
  input  logic [23:0]        pixel_x,
  input  logic [23:0]        pixel_y,
  input  logic [31:0]        base_x,
  input  logic signed [32:0] base_y,
  input  logic               last_in_group,
  output logic               done,
  output logic [1:0]         verdict,
  output logic [7:0]         group_size,
  output logic [62:0]        max_distance_sq,
  output logic [30:0]        out_x,
  output logic [30:0]        out_y,
  output logic [62:0]        out_key,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  logic [3:0]  max_duplicates;
  logic [30:0] max_distance_nm;
  logic [15:0] pixel_scale;
  logic [1:0]  ridx;
  assign ridx = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_duplicates <= 4'd5;
      max_distance_nm <= 31'd10000;
      pixel_scale <= 16'd8904;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        bdgf_pkg::REG_MAX_DUP: max_duplicates <= pwdata[3:0];
        bdgf_pkg::REG_MAX_DIST: max_distance_nm <= pwdata[30:0];
        bdgf_pkg::REG_SCALE: pixel_scale <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      bdgf_pkg::REG_MAX_DUP: prdata = {28'd0, max_duplicates};
      bdgf_pkg::REG_MAX_DIST: prdata = {1'b0, max_distance_nm};
      bdgf_pkg::REG_SCALE: prdata = {16'd0, pixel_scale};
      default: prdata = '0;
    endcase
  end

  logic q_valid;
  logic q_pop;
  logic f_idle;
  logic b_idle;
  bdgf_pkg::rec_t q_data;

  bdgf_front #(.TILE_COUNT(TILE_COUNT)) u_front (
    .clk, .rst, .start, .opcode, .tile_index, .barcode_key, .pixel_x, .pixel_y,
    .base_x, .base_y, .last_in_group, .busy, .q_valid, .q_data, .q_pop,
    .idle(f_idle)
  );

  bdgf_back #(.GROUP_DEPTH(GROUP_DEPTH), .COORD_BITS(COORD_BITS)) u_back (
    .clk, .rst, .q_valid, .q_data, .q_pop, .max_duplicates, .max_distance_nm,
    .pixel_scale, .done, .verdict, .group_size, .max_distance_sq, .out_x, .out_y,
    .out_key, .idle(b_idle)
  );

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held two cycles");
  a_idle_no_done: assert property (@(posedge clk) disable iff (rst)
    (f_idle && b_idle && !start) |=> !done)
    else $error("result without a record");
  a_too_many_zero: assert property (@(posedge clk) disable iff (rst)
    (done && verdict == bdgf_pkg::VERDICT_TOO_MANY) |-> (max_distance_sq == '0))
    else $error("too many carries a distance");
`endif
endmodule

### dv/barcode_duplicate_group_filter_tb.sv
// testbench of the barcode duplicate group filter: directed and random traffic, scoreboard check
`timescale 1ns / 1ps
module barcode_duplicate_group_filter_tb;

  localparam logic [62:0] KEY_MAX = 63'd7450580596923828124;
  localparam longint unsigned COORD_SAT = (64'd1 << 31) - 64'd1;
  localparam int STALL_LIMIT = 5000;
  localparam int EXP_DEPTH = 64;

  typedef struct {
    logic        op;
    logic [5:0]  tile;
    logic [62:0] key;
    logic [23:0] px;
    logic [23:0] py;
    logic [31:0] bx;
    logic [32:0] by;
    logic        last;
  } record_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [7:0]  size;
    logic [62:0] dist_sq;
    logic [30:0] x;
    logic [30:0] y;
    logic [62:0] key;
  } verdict_t;

  class dup_group_board;
    logic [31:0] base_x_tab[64];
    logic signed [32:0] base_y_tab[64];
    longint unsigned gx_st[8];
    longint unsigned gy_st[8];
    int unsigned rec_count;
    longint unsigned spread_sq;
    logic [62:0] first_key;
    logic [3:0]  max_dup;
    logic [30:0] max_dist;
    logic [15:0] scale;
    verdict_t    exp_ring[EXP_DEPTH];
    int unsigned exp_wr;
    int unsigned exp_rd;
    int unsigned exp_fill;
    int          mismatches;

    function new();
      rec_count = 0;
      spread_sq = 0;
      first_key = '0;
      max_dup = 4'd5;
      max_dist = 31'd10000;
      scale = 16'd8904;
      exp_wr = 0;
      exp_rd = 0;
      exp_fill = 0;
      mismatches = 0;
    endfunction

    function int unsigned outstanding();
      return exp_fill;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        bdgf_pkg::REG_MAX_DUP: max_dup = val[3:0];
        bdgf_pkg::REG_MAX_DIST: max_dist = val[30:0];
        bdgf_pkg::REG_SCALE: scale = val[15:0];
        default: ;
      endcase
    endfunction

    function longint unsigned to_nm(longint pix);
      longint unsigned v;
      if (pix <= 0) return 0;
      v = (longint'(pix) * longint'(scale)) >>> 8;
      return (v > COORD_SAT) ? COORD_SAT : v;
    endfunction

    function void note_item(record_t r);
      longint unsigned gx, gy, dx, dy, d, thr;
      int unsigned lim;
      verdict_t v;
      if (r.op == bdgf_pkg::OP_LOAD) begin
        base_x_tab[r.tile] = r.bx;
        base_y_tab[r.tile] = r.by;
        return;
      end
      gx = to_nm(longint'(base_x_tab[r.tile]) - longint'(r.px));
      gy = to_nm(longint'(base_y_tab[r.tile]) + longint'(r.py));
      lim = (max_dup > 8) ? 8 : max_dup;
      if (rec_count == 0) first_key = r.key;
      if (rec_count < lim) begin
        for (int k = 0; k < rec_count; k++) begin
          dx = (gx > gx_st[k]) ? gx - gx_st[k] : gx_st[k] - gx;
          dy = (gy > gy_st[k]) ? gy - gy_st[k] : gy_st[k] - gy;
          d = dx * dx + dy * dy;
          if (d > spread_sq) spread_sq = d;
        end
        gx_st[rec_count] = gx;
        gy_st[rec_count] = gy;
      end
      if (rec_count < 255) rec_count++;
      if (!r.last) return;
      thr = longint'(max_dist) * longint'(max_dist);
      v.size = rec_count[7:0];
      v.key = first_key;
      if (rec_count > lim) begin
        v.verdict = bdgf_pkg::VERDICT_TOO_MANY;
        v.dist_sq = '0;
        v.x = '0;
        v.y = '0;
      end else begin
        v.verdict = (spread_sq > thr) ? bdgf_pkg::VERDICT_TOO_FAR : bdgf_pkg::VERDICT_KEPT;
        v.dist_sq = spread_sq[62:0];
        v.x = gy_st[0][30:0];
        v.y = gx_st[0][30:0];
      end
      exp_ring[exp_wr] = v;
      exp_wr = (exp_wr + 1) % EXP_DEPTH;
      exp_fill++;
      rec_count = 0;
      spread_sq = 0;
    endfunction

    function void check_result(verdict_t got);
      verdict_t exp_v;
      if (exp_fill == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: key %0d", got.key);
        return;
      end
      exp_v = exp_ring[exp_rd];
      exp_rd = (exp_rd + 1) % EXP_DEPTH;
      exp_fill--;
      if (got != exp_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp v%0d n%0d d%0d x%0d y%0d k%0d",
                    " / got v%0d n%0d d%0d x%0d y%0d k%0d"},
            exp_v.verdict, exp_v.size, exp_v.dist_sq, exp_v.x, exp_v.y, exp_v.key,
            got.verdict, got.size, got.dist_sq, got.x, got.y, got.key);
      end
    endfunction
  endclass

  logic clk, rst, start, busy, opcode, last_in_group, done, psel, penable, pwrite, pready;
  logic [5:0] tile_index;
  logic [62:0] barcode_key, max_distance_sq, out_key;
  logic [23:0] pixel_x, pixel_y;
  logic [31:0] base_x, pwdata, prdata;
  logic signed [32:0] base_y;
  logic [1:0] verdict;
  logic [7:0] group_size;
  logic [30:0] out_x, out_y;
  logic [3:0] paddr;

  barcode_duplicate_group_filter dut (.*);

  dup_group_board board = new();
  bit tile_loaded[64];
  int idle_pct;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // results cannot be held off, so each strobe is one transfer
  always @(posedge clk) begin
    verdict_t got;
    if (!rst && done) begin
      got.verdict = verdict;
      got.size = group_size;
      got.dist_sq = max_distance_sq;
      got.x = out_x;
      got.y = out_y;
      got.key = out_key;
      board.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_item(record_t r);
    opcode <= r.op;
    tile_index <= r.tile;
    barcode_key <= r.key;
    pixel_x <= r.px;
    pixel_y <= r.py;
    base_x <= r.bx;
    base_y <= r.by;
    last_in_group <= r.last;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_item(r);
    if (r.op == bdgf_pkg::OP_LOAD) tile_loaded[r.tile] = 1'b1;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_reg(idx, val);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [62:0] rand_key();
    logic [62:0] k;
    do k = 63'({$urandom, $urandom}); while (k > KEY_MAX);
    return k;
  endfunction

  function automatic record_t rand_load();
    record_t r;
    logic signed [32:0] y;
    r.op = bdgf_pkg::OP_LOAD;
    r.tile = 6'($urandom_range(63));
    r.key = rand_key();
    r.px = 24'($urandom);
    r.py = 24'($urandom);
    r.last = 1'($urandom_range(1));
    r.bx = $urandom_range(1) ? $urandom : $urandom_range(0, 1 << 24);
    if ($urandom_range(1) != 0) begin
      do y = {1'($urandom_range(1)), $urandom}; while (y < -33'sd2147483648);
    end else y = $signed(33'($urandom_range(0, 1 << 24))) - 33'sd8388608;
    r.by = y;
    return r;
  endfunction

  function automatic record_t make_rec(logic [5:0] t, logic [62:0] k, logic [23:0] x,
                                       logic [23:0] y, logic l);
    record_t r;
    r.op = bdgf_pkg::OP_RECORD;
    r.tile = t;
    r.key = k;
    r.px = x;
    r.py = y;
    r.bx = $urandom;
    r.by = {1'($urandom_range(1)), $urandom};
    r.last = l;
    return r;
  endfunction

  task automatic random_traffic(int count);
    record_t r;
    int sent, n, spread;
    logic [5:0] t;
    logic [62:0] k;
    logic [23:0] cx, cy;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        push_item(rand_load());
        sent++;
      end else begin
        do t = 6'($urandom_range(63)); while (!tile_loaded[t]);
        k = rand_key();
        n = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
        case ($urandom_range(4))
          0: spread = 0;
          1: spread = 3;
          2: spread = 60;
          3: spread = 400;
          default: spread = 24'hffffff;
        endcase
        cx = 24'($urandom);
        cy = 24'($urandom);
        for (int i = 0; i < n; i++) begin
          r = make_rec(t, ($urandom_range(15) == 0) ? rand_key() : k,
                       24'(cx + $urandom_range(0, spread)),
                       24'(cy + $urandom_range(0, spread)),
                       i == n - 1);
          if ($urandom_range(19) == 0) do r.tile = 6'($urandom_range(63));
            while (!tile_loaded[r.tile]);
          push_item(r);
        end
        sent += n;
      end
    end
  endtask

  initial begin
    record_t r;
    int phase_idle[6] = '{0, 84, 0, 32, 84, 0};
    logic [3:0] dup_cfg[6] = '{4'd15, 4'd0, 4'd1, 4'd8, 4'd3, 4'd5};
    logic [30:0] dist_cfg[6] = '{31'd10000, 31'd0, 31'h7fffffff, 31'd300, 31'd2000, 31'd50000};
    logic [15:0] scale_cfg[6] = '{16'd256, 16'd0, 16'hffff, 16'd8904, 16'd1, 16'd1000};
    rst = 1'b1;
    start = 1'b0;
    opcode = bdgf_pkg::OP_LOAD;
    tile_index = '0;
    barcode_key = '0;
    pixel_x = '0;
    pixel_y = '0;
    base_x = '0;
    base_y = '0;
    last_in_group = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // tile table extremes; a load with the group flag set must not close a group
    r = rand_load();
    r.tile = 6'd0; r.bx = 32'd0; r.by = -33'sd2147483648; r.last = 1'b1;
    push_item(r);
    r.tile = 6'd63; r.bx = 32'hffffffff; r.by = 33'h0_ffff_ffff; r.last = 1'b0;
    push_item(r);
    r.tile = 6'd5; r.bx = 32'd1000; r.by = 33'sd500;
    push_item(r);
    push_item(make_rec(6'd5, 63'd0, 24'd0, 24'd0, 1'b1));
    push_item(make_rec(6'd0, KEY_MAX, 24'hffffff, 24'hffffff, 1'b1));
    push_item(make_rec(6'd63, 63'd1, 24'd0, 24'hffffff, 1'b1));
    // small cluster with a key change inside the group
    push_item(make_rec(6'd5, 63'd77, 24'd1000, 24'd0, 1'b0));
    push_item(make_rec(6'd5, 63'd78, 24'd1001, 24'd3, 1'b0));
    push_item(make_rec(6'd5, 63'd79, 24'd990, 24'd10, 1'b1));
    push_item(make_rec(6'd5, 63'd80, 24'd0, 24'd0, 1'b0));
    push_item(make_rec(6'd5, 63'd80, 24'd1000, 24'd0, 1'b1));
    for (int i = 0; i < 6; i++) push_item(make_rec(6'd5, 63'd81, 24'(i), 24'(i), i == 5));
    settle();

    for (int p = 0; p < 6; p++) begin
      write_reg(bdgf_pkg::REG_MAX_DUP, {28'd0, dup_cfg[p]});
      write_reg(bdgf_pkg::REG_MAX_DIST, {1'b0, dist_cfg[p]});
      write_reg(bdgf_pkg::REG_SCALE, {16'd0, scale_cfg[p]});
      idle_pct = phase_idle[p];
      if (p == 3) begin
        // one oversized group so the size count saturates
        for (int i = 0; i < 260; i++)
          push_item(make_rec(6'd5, 63'd99, 24'($urandom), 24'($urandom), i == 259));
      end
      random_traffic(100);
      settle();
    end

    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

### files.f
rtl/bdgf_pkg.sv
rtl/bdgf_front.sv
rtl/bdgf_back.sv
rtl/barcode_duplicate_group_filter.sv
dv/barcode_duplicate_group_filter_tb.sv
